// File: src/mctt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mctt_pkg: shared types and constants for the timeout timer bank
// Field widths, command codes and the controller-to-datapath command struct.
// -----------------------------------------------------------------------------
package mctt_pkg;

  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned TICKS_W     = 32;
  localparam int unsigned MASK_W      = 16;
  localparam int unsigned NUM_TIMERS_DEF = 16;

  localparam logic [TICKS_W-1:0] COUNT_MAX = {TICKS_W{1'b1}};

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_POLL  = 3'd3,
    ACT_QUERY = 3'd4
  } action_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic load;  // capture the incoming command beat
    logic exec;  // apply the held command and load the result register
  } dp_ctrl_t;

endpackage : mctt_pkg
`default_nettype wire

// File: src/mctt_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mctt_cmd_if: command channel
// Valid/ready channel that carries one timer command per beat.
// -----------------------------------------------------------------------------
interface mctt_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [mctt_pkg::ACTION_W-1:0] action;
  logic [mctt_pkg::INDEX_W-1:0]  timer_index;
  logic [mctt_pkg::TICKS_W-1:0]  timeout_ticks;
  logic                         auto_mode;

  modport source (
    output valid, action, timer_index, timeout_ticks, auto_mode,
    input  ready
  );

  modport sink (
    input  valid, action, timer_index, timeout_ticks, auto_mode,
    output ready
  );
endinterface : mctt_cmd_if
`default_nettype wire

// File: src/mctt_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mctt_rsp_if: response channel
// Valid/ready channel that carries one result beat per command.
// -----------------------------------------------------------------------------
interface mctt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       answer;
  logic [mctt_pkg::MASK_W-1:0] expired_mask;

  modport source (
    output valid, answer, expired_mask,
    input  ready
  );

  modport sink (
    input  valid, answer, expired_mask,
    output ready
  );
endinterface : mctt_rsp_if
`default_nettype wire

// File: src/mctt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mctt_ctrl: command sequencer
// Two-state machine that captures a command beat, executes it once the
// result register is free, and tracks the result register's valid flag.
// -----------------------------------------------------------------------------
module mctt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output mctt_pkg::dp_ctrl_t     ctrl_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic exec;
  logic accept;

  // Execute when a command is held and the result slot is free or draining
  assign exec       = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == ST_IDLE) || exec;
  assign accept     = in_valid_i && in_ready_o;

  assign ctrl_o.load = accept;
  assign ctrl_o.exec = exec;
  assign out_valid_o = out_valid_q;

  // Advance the state machine
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec && !accept) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Set the result flag on execute, drop it when the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_holds_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("accepted command not held for execution");

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> out_valid_q)
    else $error("executed command produced no result beat");

  a_no_exec_over_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !exec)
    else $error("result beat overwritten before it was taken");

endmodule : mctt_ctrl
`default_nettype wire

// File: src/mctt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mctt_datapath: timer lanes and result register
// Holds the captured command, one counter/limit/mode/running lane per timer,
// and the registered answer and expiry mask.
// -----------------------------------------------------------------------------
module mctt_datapath #(
  parameter int unsigned NumTimers = mctt_pkg::NUM_TIMERS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mctt_pkg::dp_ctrl_t            ctrl_i,
  input  wire logic [mctt_pkg::ACTION_W-1:0] action_i,
  input  wire logic [mctt_pkg::INDEX_W-1:0]  timer_index_i,
  input  wire logic [mctt_pkg::TICKS_W-1:0]  timeout_ticks_i,
  input  wire logic                          auto_mode_i,
  output logic                               answer_o,
  output logic [mctt_pkg::MASK_W-1:0]        expired_mask_o
);

  localparam int unsigned MaskW  = mctt_pkg::MASK_W;
  localparam int unsigned TicksW = mctt_pkg::TICKS_W;
  localparam int unsigned IndexW = mctt_pkg::INDEX_W;

  // Captured command
  mctt_pkg::action_e   action_q;
  logic [IndexW-1:0]   timer_index_q;
  logic [TicksW-1:0]   timeout_ticks_q;
  logic                auto_mode_q;

  // Timer lanes
  logic [NumTimers-1:0] running_q;
  logic [NumTimers-1:0] mode_q;
  logic [TicksW-1:0]    count_q [NumTimers];
  logic [TicksW-1:0]    limit_q [NumTimers];

  logic [TicksW-1:0]    count_inc [NumTimers];
  logic [NumTimers-1:0] over;
  logic [NumTimers-1:0] fire;
  logic [NumTimers-1:0] hit;
  logic                 idx_ok;

  logic                 answer_q, answer_d;
  logic [MaskW-1:0]     mask_q, mask_d;

  // Hold the command beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      action_q        <= mctt_pkg::action_e'(action_i);
      timer_index_q   <= timer_index_i;
      timeout_ticks_q <= timeout_ticks_i;
      auto_mode_q     <= auto_mode_i;
    end
  end

  assign idx_ok = {1'b0, timer_index_q} < (IndexW + 1)'(NumTimers);

  // Per-lane saturating increment, expiry compares and address decode
  always_comb begin
    for (int t = 0; t < NumTimers; t++) begin
      count_inc[t] = (count_q[t] == mctt_pkg::COUNT_MAX) ? count_q[t]
                                                         : count_q[t] + TicksW'(1);
      over[t]      = count_q[t] > limit_q[t];
      fire[t]      = running_q[t] && mode_q[t] && (count_inc[t] > limit_q[t]);
      hit[t]       = idx_ok && (timer_index_q == IndexW'(t));
    end
  end

  // Only the low timers have a bit in the expiry mask
  for (genvar i = 0; i < MaskW; i++) begin : g_mask
    if (i < NumTimers) begin : g_bit
      assign mask_d[i] = (action_q == mctt_pkg::ACT_TICK) && fire[i];
    end else begin : g_zero
      assign mask_d[i] = 1'b0;
    end
  end

  // Form the answer bit
  always_comb begin
    case (action_q)
      mctt_pkg::ACT_POLL:  answer_d = |(hit & running_q & over);
      mctt_pkg::ACT_QUERY: answer_d = |(hit & running_q);
      default:             answer_d = 1'b0;
    endcase
  end

  // Update the timer lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      mode_q    <= '0;
      for (int t = 0; t < NumTimers; t++) begin
        count_q[t] <= '0;
        limit_q[t] <= '0;
      end
    end else if (ctrl_i.exec) begin
      for (int t = 0; t < NumTimers; t++) begin
        case (action_q)
          mctt_pkg::ACT_TICK: begin
            if (running_q[t]) count_q[t] <= count_inc[t];
            if (fire[t]) running_q[t] <= 1'b0;
          end
          mctt_pkg::ACT_START: begin
            if (hit[t]) begin
              count_q[t]   <= '0;
              limit_q[t]   <= timeout_ticks_q;
              mode_q[t]    <= auto_mode_q;
              running_q[t] <= 1'b1;
            end
          end
          mctt_pkg::ACT_STOP: begin
            if (hit[t]) begin
              count_q[t]   <= '0;
              limit_q[t]   <= '0;
              running_q[t] <= 1'b0;
            end
          end
          mctt_pkg::ACT_POLL: begin
            if (hit[t] && running_q[t] && over[t]) running_q[t] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      answer_q <= answer_d;
      mask_q   <= mask_d;
    end
  end

  assign answer_o       = answer_q;
  assign expired_mask_o = mask_q;

  a_mask_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.exec && action_q != mctt_pkg::ACT_TICK) |=> mask_q == '0)
    else $error("expiry mask set by a non-tick command");

  a_tick_starts_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.exec && action_q == mctt_pkg::ACT_TICK)
      |=> (running_q & ~$past(running_q)) == '0)
    else $error("tick set a running bit");

  a_poll_halts_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.exec && action_q == mctt_pkg::ACT_POLL && answer_d)
      |=> $countones(running_q) == $countones($past(running_q)) - 1)
    else $error("expired poll did not halt exactly one timer");

endmodule : mctt_datapath
`default_nettype wire

// File: src/multi_channel_timeout_timer_bank_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted command beat is held until the result register is free or
//   draining, then executed into it; the result beat stays valid until taken.
// Throughput: one command per cycle while results are taken; every timer lane
//   updates in parallel, so a tick executes like any other command.
// Reset: all timers halted with zero count, limit and mode; no result pending.
// -----------------------------------------------------------------------------
// multi_channel_timeout_timer_bank_unit: bank of one-shot timeout timers
// Commands tick, start, stop, poll or query the timers; each returns one
// result beat with an answer bit and a per-timer expiry mask.
// -----------------------------------------------------------------------------
module multi_channel_timeout_timer_bank_unit #(
  parameter int unsigned NumTimers = mctt_pkg::NUM_TIMERS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mctt_cmd_if.sink    in_i,
  mctt_rsp_if.source  out_o
);

  mctt_pkg::dp_ctrl_t dp_ctrl;

  mctt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (dp_ctrl)
  );

  mctt_datapath #(
    .NumTimers (NumTimers)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (dp_ctrl),
    .action_i        (in_i.action),
    .timer_index_i   (in_i.timer_index),
    .timeout_ticks_i (in_i.timeout_ticks),
    .auto_mode_i     (in_i.auto_mode),
    .answer_o        (out_o.answer),
    .expired_mask_o  (out_o.expired_mask)
  );

endmodule : multi_channel_timeout_timer_bank_unit
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb: self-checking bench for the timeout timer bank
// Drives tick, start, stop, poll and query commands, plus unused codes and
// out-of-range timers, through the valid/ready command channel. Random idles
// fall on both sides, and the result side holds off once for a long stretch.
// A scoreboard keeps its own copy of every timer and checks each result beat
// in order.
// -----------------------------------------------------------------------------
module tb;
  import mctt_pkg::*;

  localparam int unsigned N_TIMERS     = NUM_TIMERS_DEF;
  localparam int unsigned ACT_CODE_MAX = (1 << ACTION_W) - 1;
  localparam int unsigned RANDOM_CMDS  = 1100;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned IDLE_PCT     = 21;

  typedef struct packed {
    logic              answer;
    logic [MASK_W-1:0] expired_mask;
  } timer_result_t;

  // Scoreboard: private copy of the timer bank and queue of expected beats
  class timer_bank_scoreboard;
    bit                 lane_running[N_TIMERS];
    bit                 lane_auto[N_TIMERS];
    logic [TICKS_W-1:0] lane_count[N_TIMERS];
    logic [TICKS_W-1:0] lane_limit[N_TIMERS];
    timer_result_t      pending_q[$];
    int unsigned        accepted;
    int unsigned        err_count;

    function new();
      for (int t = 0; t < N_TIMERS; t++) begin
        lane_running[t] = 1'b0;
        lane_auto[t]    = 1'b0;
        lane_count[t]   = '0;
        lane_limit[t]   = '0;
      end
      accepted  = 0;
      err_count = 0;
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      err_count++;
    endtask

    // Apply one accepted command to the copy and queue its result
    function void note_command(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] idx,
                               logic [TICKS_W-1:0] ticks, logic autom);
      timer_result_t res;
      bit            in_range;
      int            t;
      res      = '0;
      in_range = idx < N_TIMERS;
      t        = int'(idx);
      accepted++;
      if (act == ACT_TICK) begin
        for (int k = 0; k < N_TIMERS; k++) begin
          if (lane_running[k]) begin
            if (lane_count[k] != COUNT_MAX) lane_count[k] = lane_count[k] + TICKS_W'(1);
            if (lane_auto[k] && lane_count[k] > lane_limit[k]) begin
              lane_running[k] = 1'b0;
              if (k < MASK_W) res.expired_mask[k] = 1'b1;
            end
          end
        end
      end else if (in_range) begin
        case (act)
          ACT_START: begin
            lane_count[t]   = '0;
            lane_limit[t]   = ticks;
            lane_auto[t]    = autom;
            lane_running[t] = 1'b1;
          end
          ACT_STOP: begin
            lane_count[t]   = '0;
            lane_limit[t]   = '0;
            lane_running[t] = 1'b0;
          end
          ACT_POLL: begin
            if (lane_running[t] && lane_count[t] > lane_limit[t]) begin
              lane_running[t] = 1'b0;
              res.answer      = 1'b1;
            end
          end
          ACT_QUERY: res.answer = lane_running[t];
          default: ;
        endcase
      end
      pending_q.push_back(res);
    endfunction

    // Compare one taken result beat with the oldest expectation
    task check_result(logic answer, logic [MASK_W-1:0] mask);
      timer_result_t exp_res;
      if (pending_q.size() == 0) begin
        report($sformatf("result beat with nothing pending (answer %b mask %h)", answer, mask));
      end else begin
        exp_res = pending_q.pop_front();
        if (answer !== exp_res.answer)
          report($sformatf("answer %b, expected %b", answer, exp_res.answer));
        if (mask !== exp_res.expired_mask)
          report($sformatf("expired_mask %h, expected %h", mask, exp_res.expired_mask));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic no_gaps;
  int unsigned cycles;

  timer_bank_scoreboard sb;

  mctt_cmd_if cmd_if ();
  mctt_rsp_if rsp_if ();

  multi_channel_timeout_timer_bank_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if.sink),
    .out_o  (rsp_if.source)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Abort on a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[%0t] run exceeded %0d cycles", $realtime, CYCLE_LIMIT);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Offer one command beat, idling at random first, and hold it until taken
  task automatic send_cmd(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] idx,
                          logic [TICKS_W-1:0] ticks, logic autom);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.action        <= act;
    cmd_if.timer_index   <= idx;
    cmd_if.timeout_ticks <= ticks;
    cmd_if.auto_mode     <= autom;
    do @(posedge clk); while (!cmd_if.ready);
    sb.note_command(act, idx, ticks, autom);
  endtask

  // Result side: take beats, stall at random, hold off once for a long stretch
  initial begin
    int unsigned hold_left;
    bit          held_once;
    hold_left = 0;
    held_once = 1'b0;
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        sb.check_result(rsp_if.answer, rsp_if.expired_mask);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!held_once && sb.accepted >= 400) begin
        held_once = 1'b1;
        hold_left = 300;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Command stimulus
  initial begin
    int unsigned        roll;
    logic [ACTION_W-1:0] act;
    logic [INDEX_W-1:0]  idx;
    logic [TICKS_W-1:0]  ticks;

    sb      = new();
    no_gaps = 1'b0;
    cmd_if.valid         <= 1'b0;
    cmd_if.action        <= ACT_TICK;
    cmd_if.timer_index   <= '0;
    cmd_if.timeout_ticks <= '0;
    cmd_if.auto_mode     <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);

    // Directed: idle bank, auto expiry at limit zero, polled expiry and re-poll
    send_cmd(ACT_QUERY, 8'd0, 32'd0, 1'b0);
    send_cmd(ACT_TICK, 8'd0, 32'd0, 1'b0);
    send_cmd(ACT_START, 8'd0, 32'd0, 1'b1);
    send_cmd(ACT_START, 8'd15, 32'd2, 1'b0);
    send_cmd(ACT_POLL, 8'd15, 32'd0, 1'b0);
    send_cmd(ACT_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_cmd(ACT_TICK, 8'd0, 32'd0, 1'b0);
    send_cmd(ACT_TICK, 8'd0, 32'd0, 1'b0);
    send_cmd(ACT_POLL, 8'd15, 32'd0, 1'b0);
    send_cmd(ACT_POLL, 8'd15, 32'd0, 1'b0);
    // Maximum limit never expires; stop halts it
    send_cmd(ACT_START, 8'd3, 32'hFFFF_FFFF, 1'b1);
    send_cmd(ACT_TICK, 8'd0, 32'd0, 1'b0);
    send_cmd(ACT_QUERY, 8'd3, 32'd0, 1'b0);
    send_cmd(ACT_STOP, 8'd3, 32'd0, 1'b0);
    send_cmd(ACT_QUERY, 8'd3, 32'd0, 1'b0);
    // Restart a running timer with a shorter limit
    send_cmd(ACT_START, 8'd7, 32'd5, 1'b1);
    send_cmd(ACT_START, 8'd7, 32'd1, 1'b1);
    send_cmd(ACT_TICK, 8'd0, 32'd0, 1'b0);
    send_cmd(ACT_TICK, 8'd0, 32'd0, 1'b0);
    // Out-of-range timers and unused action codes do nothing
    send_cmd(ACT_START, 8'd16, 32'd0, 1'b1);
    send_cmd(ACT_QUERY, 8'd16, 32'd0, 1'b0);
    send_cmd(ACT_STOP, 8'hFF, 32'd0, 1'b0);
    send_cmd(ACT_POLL, 8'd200, 32'd0, 1'b0);
    for (int c = ACT_QUERY + 1; c <= ACT_CODE_MAX; c++)
      send_cmd(ACTION_W'(c), INDEX_W'($urandom_range(N_TIMERS - 1)), $urandom, 1'($urandom));

    // Random: mostly well-formed traffic on real timers with short limits
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      no_gaps = (n >= 500 && n < 700);
      roll  = $urandom_range(99);
      idx   = ($urandom_range(99) < 92) ? INDEX_W'($urandom_range(N_TIMERS - 1))
                                        : INDEX_W'($urandom);
      ticks = $urandom;
      if (roll < 30)      act = ACT_TICK;
      else if (roll < 50) act = ACT_START;
      else if (roll < 58) act = ACT_STOP;
      else if (roll < 77) act = ACT_POLL;
      else if (roll < 97) act = ACT_QUERY;
      else                act = ACTION_W'($urandom_range(ACT_CODE_MAX, ACT_QUERY + 1));
      if (act == ACT_START) begin
        roll = $urandom_range(99);
        if (roll < 70)      ticks = $urandom_range(8);
        else if (roll < 85) ticks = $urandom_range(64);
        else if (roll < 95) ticks = $urandom;
        else                ticks = COUNT_MAX;
      end
      send_cmd(act, idx, ticks, 1'($urandom));
    end
    no_gaps = 1'b0;
    cmd_if.valid <= 1'b0;

    // Drain, then keep clocking to catch stray beats
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.err_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule : tb
